FILE: design/fat12_pkg.sv
package fat12_pkg;

  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned LBA_W     = 20;
  localparam int unsigned PROD_W    = 20;

  localparam logic [CLUSTER_W-1:0] ENTRY_MASK         = 12'hfff;
  localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hff8;
  localparam int unsigned          ODD_SHIFT          = 4;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
  localparam logic [LBA_W-1:0]     LBA_MAX            = 20'hfffff;

  localparam logic REG_DATA_START_LBA      = 1'b0;
  localparam logic REG_SECTORS_PER_CLUSTER = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_CHAIN    = 2'd1,
    STAT_LOW_CLUSTER = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } walk_state_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } table_req_t;

endpackage

FILE: design/fat12_table_ram.sv
module fat12_table_ram import fat12_pkg::*; #(
  parameter int unsigned TableBytes = 8192
) (
  input  logic       clk_i,
  input  table_req_t req_i,
  output logic [7:0] rd_lo_o,
  output logic [7:0] rd_hi_o
);

  localparam int unsigned IdxW = $clog2(TableBytes);

  logic [7:0]        mem_q [TableBytes];
  logic [7:0]        rd_lo_q;
  logic [7:0]        rd_hi_q;
  logic [ADDR_W-1:0] rd_addr_hi;
  logic              wr_ok;
  logic              lo_ok;
  logic              hi_ok;

  assign rd_addr_hi = req_i.rd_addr + ADDR_W'(1);
  assign wr_ok = {1'b0, req_i.wr_addr} < (ADDR_W + 1)'(TableBytes);
  assign lo_ok = {1'b0, req_i.rd_addr} < (ADDR_W + 1)'(TableBytes);
  assign hi_ok = {1'b0, rd_addr_hi} < (ADDR_W + 1)'(TableBytes);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_ok) begin
      mem_q[req_i.wr_addr[IdxW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_lo_q <= lo_ok ? mem_q[req_i.rd_addr[IdxW-1:0]] : 8'd0;
      rd_hi_q <= hi_ok ? mem_q[rd_addr_hi[IdxW-1:0]] : 8'd0;
    end
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

FILE: design/fat12_walk_ctrl.sv
module fat12_walk_ctrl import fat12_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [ADDR_W-1:0]    table_address_i,
  input  logic [7:0]           table_byte_i,
  input  logic [CLUSTER_W-1:0] start_cluster_i,
  input  logic [15:0]          data_start_lba_i,
  input  logic [7:0]           sectors_per_cluster_i,
  output table_req_t           req_o,
  input  logic [7:0]           rd_lo_i,
  input  logic [7:0]           rd_hi_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LBA_W-1:0]     sector_lba_o,
  output logic [CLUSTER_W-1:0] cluster_number_o,
  output logic [CLUSTER_W-1:0] next_cluster_o,
  output logic                 chain_end_o,
  output logic [1:0]           status_o
);

  walk_state_e          state_q, state_d;
  logic [CLUSTER_W-1:0] cur_q, cur_d;
  logic                 active_q, active_d;
  logic [CLUSTER_W-1:0] cl_q, cl_d;
  status_e              stat_q, stat_d;
  logic [PROD_W-1:0]    prod_q, prod_d;

  logic                 out_valid_q, out_valid_d;
  logic [LBA_W-1:0]     out_lba_q, out_lba_d;
  logic [CLUSTER_W-1:0] out_cl_q, out_cl_d;
  logic [CLUSTER_W-1:0] out_next_q, out_next_d;
  logic                 out_end_q, out_end_d;
  logic [1:0]           out_stat_q, out_stat_d;

  logic                 in_accept;
  logic                 out_free;
  logic [15:0]          word;
  logic [CLUSTER_W-1:0] next_cl;
  logic                 next_end;
  logic [LBA_W:0]       lba_sum;
  logic [LBA_W-1:0]     lba_sat;
  logic [CLUSTER_W-1:0] cl_m2;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign word     = {rd_hi_i, rd_lo_i};
  assign next_cl  = cl_q[0] ? CLUSTER_W'(word >> ODD_SHIFT) : (word[CLUSTER_W-1:0] & ENTRY_MASK);
  assign next_end = next_cl >= END_MARK;
  assign lba_sum  = {{(LBA_W - 15){1'b0}}, data_start_lba_i} + {1'b0, prod_q};
  assign lba_sat  = (lba_sum > {1'b0, LBA_MAX}) ? LBA_MAX : lba_sum[LBA_W-1:0];
  assign cl_m2    = cur_q - FIRST_DATA_CLUSTER;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    active_d    = active_q;
    cl_d        = cl_q;
    stat_d      = stat_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_lba_d   = out_lba_q;
    out_cl_d    = out_cl_q;
    out_next_d  = out_next_q;
    out_end_d   = out_end_q;
    out_stat_d  = out_stat_q;
    req_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (kind_e'(kind_i))
            KIND_WRITE: begin
              req_o.wr_en   = 1'b1;
              req_o.wr_addr = table_address_i;
              req_o.wr_data = table_byte_i;
            end
            KIND_START: begin
              cur_d    = start_cluster_i;
              active_d = 1'b1;
            end
            KIND_STEP: begin
              cl_d    = cur_q;
              prod_d  = PROD_W'({8'd0, cl_m2} * {12'd0, sectors_per_cluster_i});
              state_d = ST_LOAD;
              if (!active_q) begin
                stat_d = STAT_NO_CHAIN;
              end else if (cur_q < FIRST_DATA_CLUSTER) begin
                stat_d   = STAT_LOW_CLUSTER;
                active_d = 1'b0;
              end else begin
                stat_d        = STAT_OK;
                req_o.rd_en   = 1'b1;
                req_o.rd_addr = {1'b0, cur_q} + {2'b00, cur_q[CLUSTER_W-1:1]};
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_lba_d   = '0;
          out_cl_d    = '0;
          out_next_d  = '0;
          out_end_d   = 1'b0;
          case (stat_q)
            STAT_OK: begin
              out_lba_d  = lba_sat;
              out_cl_d   = cl_q;
              out_next_d = next_cl;
              out_end_d  = next_end;
              if (next_end) begin
                active_d = 1'b0;
              end else begin
                cur_d = next_cl;
              end
            end
            STAT_LOW_CLUSTER: begin
              out_cl_d = cl_q;
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q       <= cl_d;
    stat_q     <= stat_d;
    prod_q     <= prod_d;
    out_lba_q  <= out_lba_d;
    out_cl_q   <= out_cl_d;
    out_next_q <= out_next_d;
    out_end_q  <= out_end_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o      = out_valid_q;
  assign sector_lba_o     = out_lba_q;
  assign cluster_number_o = out_cl_q;
  assign next_cluster_o   = out_next_q;
  assign chain_end_o      = out_end_q;
  assign status_o         = out_stat_q;

endmodule

FILE: design/fat12_cluster_chain_walker_core.sv
// FAT12 cluster chain walker.
// Input channel (in_valid_i / in_stall_o): kind_i selects a table byte write
// (table_address_i, table_byte_i), a chain start (start_cluster_i) or a step.
// A transaction is taken when valid is high and stall is low.
// Writes and starts produce nothing and leave the walker idle. A step produces
// one result on the output channel (out_valid_o / out_stall_i): sector LBA,
// cluster number, next table entry, end flag and status.
// A step first reads both entry bytes from the synchronous table RAM (two
// read ports, registered outputs); in the load state it decodes the entry,
// adds the registered LBA product and loads the output register. The result
// is visible the cycle after that load. The next cluster feeds back through
// the current cluster register, so steps run one at a time.
// The output register holds a result while out_stall_i is high; writes and
// starts are still taken meanwhile, a following step waits in the load state
// until the output register frees up.
// Config port (cfg_valid_i / cfg_ready_o, always ready): index 0 data start
// LBA, index 1 sectors per cluster. Write it only while the block is idle.
// Reset clears the chain state and the data start LBA and sets sectors per
// cluster to 1; table contents are undefined until written.
module fat12_cluster_chain_walker_core import fat12_pkg::*; #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [ADDR_W-1:0]    table_address_i,
  input  logic [7:0]           table_byte_i,
  input  logic [CLUSTER_W-1:0] start_cluster_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LBA_W-1:0]     sector_lba_o,
  output logic [CLUSTER_W-1:0] cluster_number_o,
  output logic [CLUSTER_W-1:0] next_cluster_o,
  output logic                 chain_end_o,
  output logic [1:0]           status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic [15:0] data_start_q;
  logic [7:0]  spc_q;
  table_req_t  req;
  logic [7:0]  rd_lo;
  logic [7:0]  rd_hi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= 16'd0;
      spc_q        <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DATA_START_LBA:      data_start_q <= cfg_data_i;
        REG_SECTORS_PER_CLUSTER: spc_q        <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  fat12_table_ram #(
    .TableBytes(TABLE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_lo_o(rd_lo),
    .rd_hi_o(rd_hi)
  );

  fat12_walk_ctrl u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .kind_i               (kind_i),
    .table_address_i      (table_address_i),
    .table_byte_i         (table_byte_i),
    .start_cluster_i      (start_cluster_i),
    .data_start_lba_i     (data_start_q),
    .sectors_per_cluster_i(spc_q),
    .req_o                (req),
    .rd_lo_i              (rd_lo),
    .rd_hi_i              (rd_hi),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .sector_lba_o         (sector_lba_o),
    .cluster_number_o     (cluster_number_o),
    .next_cluster_o       (next_cluster_o),
    .chain_end_o          (chain_end_o),
    .status_o             (status_o)
  );

endmodule

FILE: design/fat12_walker_checker.sv
module fat12_walker_checker import fat12_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [1:0]           kind_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [LBA_W-1:0]     sector_lba_o,
  input logic [CLUSTER_W-1:0] cluster_number_o,
  input logic [CLUSTER_W-1:0] next_cluster_o,
  input logic                 chain_end_o,
  input logic [1:0]           status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sector_lba_o)
      && $stable(next_cluster_o) && $stable(status_o))
    else $error("stalled result changed");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == KIND_STEP |=> in_stall_o)
    else $error("step did not occupy the walker");

  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK |-> chain_end_o == (next_cluster_o >= END_MARK))
    else $error("end flag does not match entry");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> sector_lba_o == '0 && next_cluster_o == '0
      && !chain_end_o)
    else $error("error result carries data");

  a_low_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_LOW_CLUSTER |-> cluster_number_o < FIRST_DATA_CLUSTER)
    else $error("low cluster status on a data cluster");

endmodule

bind fat12_cluster_chain_walker_core fat12_walker_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sector_lba_o    (sector_lba_o),
  .cluster_number_o(cluster_number_o),
  .next_cluster_o  (next_cluster_o),
  .chain_end_o     (chain_end_o),
  .status_o        (status_o)
);
